[rtl/core/can_alias_allocation_controller_assert.svh]
// ----------------------------------------------------------------------------
// alias allocation controller: assertion macros
// clocked on aclk, quiet while aresetn is low unless noted
// ----------------------------------------------------------------------------
`ifndef CAN_ALIAS_ALLOCATION_CONTROLLER_ASSERT_SVH
`define CAN_ALIAS_ALLOCATION_CONTROLLER_ASSERT_SVH

// same-cycle implication outside reset
`define CAAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("caac: implication violated");

// next-cycle implication outside reset
`define CAAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("caac: next-cycle check violated");

// next-cycle implication that also holds through reset
`define CAAC_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("caac: reset check violated");

`endif

[rtl/core/caac_pkg.sv]
// ----------------------------------------------------------------------------
// caac_pkg
// types, codes and helpers shared by the alias allocation controller
// ----------------------------------------------------------------------------
package caac_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_RESEED  = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    // received frame kinds
    localparam logic [2:0] FK_CHECK         = 3'd0;
    localparam logic [2:0] FK_VERIFY_GLOBAL = 3'd2;
    localparam logic [2:0] FK_VERIFY_ADDR   = 3'd3;

    // frames sent
    localparam logic [2:0] SEND_NONE     = 3'd0;
    localparam logic [2:0] SEND_CHECK    = 3'd1;
    localparam logic [2:0] SEND_RESERVE  = 3'd2;
    localparam logic [2:0] SEND_INIT     = 3'd3;
    localparam logic [2:0] SEND_VERIFIED = 3'd4;

    // configuration register indexes
    localparam logic REG_NODE_ID      = 1'b0;
    localparam logic REG_CONFIRM_WAIT = 1'b1;

    localparam logic [15:0] CONFIRM_WAIT_RESET = 16'd500;

    // generator increments
    localparam logic [23:0] GEN_LO_INC = 24'h7A4BA9;
    localparam logic [23:0] GEN_HI_INC = 24'h1B0CA3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic        tx_ready;
        logic [2:0]  frame_kind;
        logic [11:0] src_alias;
        logic [11:0] dest_alias;
        logic        has_node_id;
        logic [47:0] frame_node_id;
    } in_t;

    typedef struct packed {
        logic [2:0]  send_kind;
        logic [1:0]  check_seq;
        logic [11:0] fragment;
        logic [11:0] alias_res;
        logic        initialized;
    } out_t;

    typedef struct packed {
        logic [23:0] hi;
        logic [23:0] lo;
    } gen_t;

    function automatic logic [11:0] alias_of(gen_t g);
        return g.hi[11:0] ^ g.hi[23:12] ^ g.lo[11:0] ^ g.lo[23:12];
    endfunction

endpackage

[rtl/core/caac_gen.sv]
// ----------------------------------------------------------------------------
// caac_gen
// one step of the two-word pseudo-random alias generator
// ----------------------------------------------------------------------------
module caac_gen (
    input  caac_pkg::gen_t cur,
    output caac_pkg::gen_t nxt
);
    import caac_pkg::*;

    logic [23:0] t1;
    logic [23:0] t2;
    logic [25:0] lo_sum;
    logic [23:0] hi_sum;

    assign t1 = {cur.hi[14:0], cur.lo[23:15]};
    assign t2 = {cur.lo[14:0], 9'b0};

    // low word keeps its carry, which feeds the high word
    assign lo_sum = {2'b0, cur.lo} + {2'b0, t2} + {2'b0, GEN_LO_INC};
    assign hi_sum = cur.hi + t1 + GEN_HI_INC + {22'b0, lo_sum[25:24]};

    assign nxt.lo = lo_sum[23:0];
    assign nxt.hi = hi_sum;

endmodule

[rtl/core/can_alias_allocation_controller.sv]
// ----------------------------------------------------------------------------
// can_alias_allocation_controller: bus alias claim, check/reserve, verify
// datapath: input word registered in the input reg, then the result registered in the result reg
// throughput: one word per cycle while the output is not stalled, set by the single-pass state update
// reset: aresetn low clears state, pipeline valids and config registers to defaults
// ----------------------------------------------------------------------------
module can_alias_allocation_controller (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [47:0]    cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  caac_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output caac_pkg::out_t m_data
);
    import caac_pkg::*;

    localparam logic [2:0] PH_CHECK0     = 3'd0;
    localparam logic [2:0] PH_CHECK1     = 3'd1;
    localparam logic [2:0] PH_CHECK2     = 3'd2;
    localparam logic [2:0] PH_CHECK3     = 3'd3;
    localparam logic [2:0] PH_LAST_CHECK = 3'd4;
    localparam logic [2:0] PH_WAIT       = 3'd5;
    localparam logic [2:0] PH_RESERVED   = 3'd6;
    localparam logic [2:0] PH_INIT       = 3'd7;

    logic        in_valid_reg;
    in_t         in_reg;
    logic        out_valid_reg;
    out_t        out_reg;
    logic        advance;

    logic [47:0] node_id_reg;
    logic [15:0] confirm_wait_reg;
    logic [2:0]  phase_reg, phase_next;
    gen_t        gen_reg, gen_next, gen_stepped;
    logic [31:0] wait_start_reg, wait_start_next;
    logic [31:0] limit;
    out_t        out_next;

    caac_gen u_gen (
        .cur (gen_reg),
        .nxt (gen_stepped)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign limit   = wait_start_reg + {16'b0, confirm_wait_reg};

    always_comb begin
        phase_next         = phase_reg;
        gen_next           = gen_reg;
        wait_start_next    = wait_start_reg;
        out_next.send_kind = SEND_NONE;
        out_next.check_seq = 2'd0;
        out_next.fragment  = 12'd0;
        unique case (in_reg.opcode)
            OP_TICK: begin
                unique case (phase_reg) inside
                    PH_CHECK0, PH_CHECK1, PH_CHECK2, PH_CHECK3: begin
                        if (in_reg.tx_ready) begin
                            out_next.send_kind = SEND_CHECK;
                            out_next.check_seq = phase_reg[1:0];
                            case (phase_reg[1:0])
                                2'd0:    out_next.fragment = node_id_reg[47:36];
                                2'd1:    out_next.fragment = node_id_reg[35:24];
                                2'd2:    out_next.fragment = node_id_reg[23:12];
                                default: out_next.fragment = node_id_reg[11:0];
                            endcase
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                    PH_LAST_CHECK: begin
                        wait_start_next = in_reg.now_ms;
                        phase_next      = PH_WAIT;
                    end
                    PH_WAIT: begin
                        if (in_reg.now_ms > limit && in_reg.tx_ready) begin
                            out_next.send_kind = SEND_RESERVE;
                            phase_next         = PH_RESERVED;
                        end
                    end
                    PH_RESERVED: begin
                        if (in_reg.tx_ready) begin
                            out_next.send_kind = SEND_INIT;
                            phase_next         = PH_INIT;
                        end
                    end
                    PH_INIT: begin
                        phase_next = PH_INIT;
                    end
                endcase
            end
            OP_FRAME: begin
                if (alias_of(gen_reg) == in_reg.src_alias) begin
                    if (in_reg.frame_kind == FK_CHECK) begin
                        out_next.send_kind = SEND_RESERVE;
                    end else begin
                        phase_next = PH_CHECK0;
                        gen_next   = gen_stepped;
                    end
                end
                // addressed verify requests are judged against the alias after any restart
                if (in_reg.frame_kind == FK_VERIFY_GLOBAL) begin
                    if (!in_reg.has_node_id || in_reg.frame_node_id == node_id_reg) begin
                        out_next.send_kind = SEND_VERIFIED;
                    end
                end else if (in_reg.frame_kind == FK_VERIFY_ADDR &&
                             in_reg.dest_alias == alias_of(gen_next)) begin
                    out_next.send_kind = SEND_VERIFIED;
                end
            end
            OP_RESEED: begin
                gen_next.hi = node_id_reg[47:24];
                gen_next.lo = node_id_reg[23:0];
            end
            OP_RESTART: begin
                phase_next = PH_CHECK0;
                gen_next   = gen_stepped;
            end
        endcase
        out_next.alias_res   = alias_of(gen_next);
        out_next.initialized = (phase_next == PH_INIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_CHECK0;
            gen_reg          <= '0;
            wait_start_reg   <= '0;
            node_id_reg      <= '0;
            confirm_wait_reg <= CONFIRM_WAIT_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                gen_reg        <= gen_next;
                wait_start_reg <= wait_start_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_NODE_ID:      node_id_reg      <= cfg_wdata;
                    REG_CONFIRM_WAIT: confirm_wait_reg <= cfg_wdata[15:0];
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

[rtl/core/caac_checker.sv]
// ----------------------------------------------------------------------------
// caac_checker
// port-level checks on the alias allocation controller, bound to the top level
// ----------------------------------------------------------------------------
`include "can_alias_allocation_controller_assert.svh"

module caac_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input caac_pkg::out_t m_data
);
    import caac_pkg::*;

    logic frag_clear;

    assign frag_clear = (m_data.check_seq == 2'd0) && (m_data.fragment == 12'd0);

    // a stalled result word holds
    `CAAC_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // fragment and ordinal only ride on check-id words
    `CAAC_ASSERT_IMP(a_frag_only_check, m_valid && m_data.send_kind != SEND_CHECK, frag_clear)

    // sending init complete means we are initialized
    `CAAC_ASSERT_IMP(a_init_flag, m_valid && m_data.send_kind == SEND_INIT, m_data.initialized)

    // no result word straight out of reset, and the input is ready
    `CAAC_ASSERT_NXT_ALWAYS(a_reset_empty, !aresetn, !m_valid && s_ready)

endmodule

bind can_alias_allocation_controller caac_checker u_caac_checker (.*);
